>>> design/sdds_pkg.sv
package sdds_pkg;

	// One column of the LED bar: bit 6 is the top row.
	typedef logic [6:0] glyph_col_t;

	// Decimal digits of the latched distance, split for display.
	typedef struct packed {
		logic [3:0] hundreds;
		logic [3:0] tens;
		logic [3:0] units;
	} dist_digits_t;

	// Register map: register index taken from the word address.
	localparam logic REG_COLUMN_TICKS = 1'b0;
	localparam logic [15:0] COLUMN_TICKS_RESET = 16'd1191;

	// Distance conversion: floor(echo * 67 / 64000), saturated to 999.
	// Echo counts at or above this value give 1000 cm or more.
	localparam logic [31:0] DIST_SAT_ECHO = 32'd955224;
	localparam logic [9:0] DIST_MAX = 10'd999;
	// floor(q / 125) for q below 125000 as (q * 134218) >> 24.
	localparam logic [17:0] DIST_RECIP = 18'd134218;

	// First column of each glyph in the scan; every glyph is five columns wide.
	localparam int unsigned HUND_FIRST = 28;
	localparam int unsigned TENS_FIRST = 34;
	localparam int unsigned UNITS_FIRST = 40;
	localparam int unsigned LETTER_C_FIRST = 46;
	localparam int unsigned LETTER_M_FIRST = 52;
	localparam int unsigned GLYPH_WIDTH = 5;

	localparam glyph_col_t DIGIT_FONT [0:9][0:4] = '{
		'{7'h7F, 7'h41, 7'h41, 7'h41, 7'h7F},
		'{7'h00, 7'h00, 7'h00, 7'h00, 7'h7F},
		'{7'h4F, 7'h49, 7'h49, 7'h49, 7'h79},
		'{7'h49, 7'h49, 7'h49, 7'h49, 7'h7F},
		'{7'h78, 7'h08, 7'h08, 7'h08, 7'h7F},
		'{7'h79, 7'h49, 7'h49, 7'h49, 7'h4F},
		'{7'h7F, 7'h49, 7'h49, 7'h49, 7'h4F},
		'{7'h40, 7'h40, 7'h40, 7'h40, 7'h7F},
		'{7'h7F, 7'h49, 7'h49, 7'h49, 7'h7F},
		'{7'h79, 7'h49, 7'h49, 7'h49, 7'h7F}
	};
	localparam glyph_col_t LETTER_C [0:4] = '{7'h0F, 7'h09, 7'h09, 7'h09, 7'h09};
	localparam glyph_col_t LETTER_M [0:4] = '{7'h0F, 7'h08, 7'h0F, 7'h08, 7'h0F};

endpackage

>>> design/swing_display_distance_scanner_core.sv
// Persistence-of-vision column driver for a swinging LED bar. Every input word is one
// display tick and produces exactly one output word, in the cycle after it is taken, through
// an output register; a new word is taken every cycle while the output side keeps up, so the
// sustained rate is one word per clock. When the swing
// sensor turns active (swing_level low) the echo count is converted to centimeters,
// floor(echo * 67 / 64000) saturated to 999. When it turns inactive a scan of COLUMNS
// columns starts, each column lasting column_ticks words (0 acts as 1); the hundreds,
// tens and units digits, then "C" and "M", appear at columns 28, 34, 40, 46 and 52.
// Sensor edges are ignored during a scan. column_ticks sits at byte address 0 of the
// register port and should only be written while no words are in flight.
module swing_display_distance_scanner_core
	import sdds_pkg::*;
#(
	parameter int unsigned COLUMNS = 80
) (
	input  logic        clk,
	input  logic        arst_n,
	// Input stream.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // [0] swing_level, [32:1] echo_ticks, [39:33] zero
	// Output stream.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,  // [6:0] led_column, [7] scanning, [17:8] distance_cm
	// Register port.
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int unsigned COL_W = $clog2(COLUMNS);

	logic             active;
	logic [31:0]      echo;
	logic             in_fire;

	logic [15:0]      column_ticks_q;
	logic             prev_active_q;
	logic [9:0]       latched_q;
	logic             busy_q;
	logic [COL_W-1:0] col_q;
	logic [15:0]      tick_q;
	dist_digits_t     digits_q;

	logic             m_valid_q;
	glyph_col_t       out_led_q;
	logic             out_scan_q;
	logic [9:0]       out_dist_q;

	logic [19:0]      echo_lo;
	logic [26:0]      echo_x67;
	logic [16:0]      dist_coarse;
	logic [34:0]      dist_prod;
	logic [9:0]       dist_new;

	logic             edge_seen;
	logic             do_latch;
	logic             do_start;
	logic             busy_now;
	logic [9:0]       latched_next;
	logic [COL_W-1:0] col_cur;
	logic [15:0]      tick_cur;
	logic [16:0]      tick_inc;
	logic             col_done;
	logic             scan_done;
	glyph_col_t       led_now;

	logic [17:0]      d_x205;
	logic [15:0]      d_x41;
	logic [6:0]       d_div10;
	logic [3:0]       d_hund;
	logic [6:0]       d_tens_w;
	logic [9:0]       d_units_w;

	assign active  = ~s_tdata[0];
	assign echo    = s_tdata[32:1];
	assign s_tready = ~m_valid_q | m_tready;
	assign in_fire = s_tvalid & s_tready;

	// Register port: single register, selected by the word address.
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_COLUMN_TICKS) ? {16'd0, column_ticks_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_ticks_q <= COLUMN_TICKS_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_COLUMN_TICKS) begin
			column_ticks_q <= pwdata[15:0];
		end
	end

	// Echo to centimeters. The product by 67 is a shift-add; the divide by 64000 is a
	// shift by 9 followed by a reciprocal multiply for the remaining factor of 125.
	assign echo_lo     = echo[19:0];
	assign echo_x67    = {1'b0, echo_lo, 6'd0} + {6'd0, echo_lo, 1'b0} + {7'd0, echo_lo};
	assign dist_coarse = echo_x67[25:9];
	assign dist_prod   = {18'd0, dist_coarse} * {17'd0, DIST_RECIP};
	assign dist_new    = (echo >= DIST_SAT_ECHO) ? DIST_MAX : dist_prod[33:24];

	// Edge detection outside a scan and the scan sequencing for this word.
	assign edge_seen    = ~busy_q & (active != prev_active_q);
	assign do_latch     = edge_seen & active;
	assign do_start     = edge_seen & ~active;
	assign busy_now     = busy_q | do_start;
	assign latched_next = do_latch ? dist_new : latched_q;
	assign col_cur      = do_start ? '0 : col_q;
	assign tick_cur     = do_start ? 16'd0 : tick_q;
	assign tick_inc     = {1'b0, tick_cur} + 17'd1;
	assign col_done     = tick_inc >= {1'b0, column_ticks_q};
	assign scan_done    = col_done && col_cur == COL_W'(COLUMNS - 1);

	// Column pattern from the registered digits.
	always_comb begin
		led_now = '0;
		if (col_cur >= COL_W'(HUND_FIRST) && col_cur < COL_W'(HUND_FIRST + GLYPH_WIDTH)) begin
			led_now = DIGIT_FONT[digits_q.hundreds][3'(col_cur - COL_W'(HUND_FIRST))];
		end else if (col_cur >= COL_W'(TENS_FIRST)
				&& col_cur < COL_W'(TENS_FIRST + GLYPH_WIDTH)) begin
			led_now = DIGIT_FONT[digits_q.tens][3'(col_cur - COL_W'(TENS_FIRST))];
		end else if (col_cur >= COL_W'(UNITS_FIRST)
				&& col_cur < COL_W'(UNITS_FIRST + GLYPH_WIDTH)) begin
			led_now = DIGIT_FONT[digits_q.units][3'(col_cur - COL_W'(UNITS_FIRST))];
		end else if (col_cur >= COL_W'(LETTER_C_FIRST)
				&& col_cur < COL_W'(LETTER_C_FIRST + GLYPH_WIDTH)) begin
			led_now = LETTER_C[3'(col_cur - COL_W'(LETTER_C_FIRST))];
		end else if (col_cur >= COL_W'(LETTER_M_FIRST)
				&& col_cur < COL_W'(LETTER_M_FIRST + GLYPH_WIDTH)) begin
			led_now = LETTER_M[3'(col_cur - COL_W'(LETTER_M_FIRST))];
		end
	end

	// Scan and latch state advances once per accepted word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_active_q <= 1'b0;
			latched_q     <= '0;
			busy_q        <= 1'b0;
			col_q         <= '0;
			tick_q        <= '0;
		end else if (in_fire) begin
			if (!busy_q) begin
				prev_active_q <= active;
			end
			latched_q <= latched_next;
			if (busy_now) begin
				if (scan_done) begin
					busy_q <= 1'b0;
					col_q  <= '0;
					tick_q <= '0;
				end else if (col_done) begin
					busy_q <= 1'b1;
					col_q  <= col_cur + COL_W'(1);
					tick_q <= '0;
				end else begin
					busy_q <= 1'b1;
					col_q  <= col_cur;
					tick_q <= tick_inc[15:0];
				end
			end
		end
	end

	// Digit split of the latched distance (below 1000), registered in the cycle after the latch.
	// A scan can only start on a later word, so the digits are ready when shown.
	assign d_x205    = {8'd0, latched_q} * 18'd205;
	assign d_x41     = {6'd0, latched_q} * 16'd41;
	assign d_div10   = d_x205[17:11];
	assign d_hund    = d_x41[15:12];
	assign d_tens_w  = d_div10 - ({3'd0, d_hund} * 7'd10);
	assign d_units_w = latched_q - ({3'd0, d_div10} * 10'd10);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digits_q <= '0;
		end else begin
			digits_q.hundreds <= d_hund;
			digits_q.tens     <= d_tens_w[3:0];
			digits_q.units    <= d_units_w[3:0];
		end
	end

	// Output register: holds a word until taken, takes a new one in the same cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (s_tready) begin
			m_valid_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			out_led_q  <= busy_now ? led_now : 7'd0;
			out_scan_q <= busy_now;
			out_dist_q <= latched_next;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {6'd0, out_dist_q, out_scan_q, out_led_q};

`ifndef SYNTHESIS
	// Column and tick counters rest at zero between scans.
	assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> (col_q == '0 && tick_q == 16'd0))
		else $error("scan counters not cleared while idle");

	// The column counter never runs past the last column.
	assert property (@(posedge clk) disable iff (!arst_n)
		col_q <= COL_W'(COLUMNS - 1))
		else $error("column index out of range");

	// The latched distance stays within the saturation limit.
	assert property (@(posedge clk) disable iff (!arst_n)
		latched_q <= DIST_MAX)
		else $error("latched distance above limit");

	// Digits follow the latched distance in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		$stable(latched_q) |=> (10'(digits_q.hundreds) * 10'd100
			+ 10'(digits_q.tens) * 10'd10 + 10'(digits_q.units)) == $past(latched_q))
		else $error("display digits do not match latched distance");

	// A word shown outside a scan has all LEDs dark.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && !out_scan_q) |-> out_led_q == 7'd0)
		else $error("LEDs lit outside a scan");
`endif

endmodule

>>> tb/swing_display_scan_checker.sv
module swing_display_scan_checker
	import sdds_pkg::*;
#(
	parameter int unsigned COLUMNS = 80
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [39:0] s_tdata,  // [0] swing_level, [32:1] echo_ticks, [39:33] zero
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [23:0] m_tdata,  // [6:0] led_column, [7] scanning, [17:8] distance_cm
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	output int unsigned fail_count,
	output int unsigned pending,
	output int unsigned checked_count,
	output int unsigned scans_started,
	output int unsigned distances_latched
);
	timeunit 1ns;
	timeprecision 1ps;

	// Where each glyph starts within the scan.
	localparam int unsigned FIRST_HUNDREDS = 28;
	localparam int unsigned FIRST_TENS = 34;
	localparam int unsigned FIRST_UNITS = 40;
	localparam int unsigned FIRST_C = 46;
	localparam int unsigned FIRST_M = 52;
	localparam int unsigned GLYPH_COLUMNS = 5;
	localparam logic [9:0] CM_LIMIT = 10'd999;

	// Glyphs are packed with their leftmost column in the top seven bits.
	localparam logic [34:0] GLYPH_C = {7'h0F, 7'h09, 7'h09, 7'h09, 7'h09};
	localparam logic [34:0] GLYPH_M = {7'h0F, 7'h08, 7'h0F, 7'h08, 7'h0F};

	typedef struct packed {
		logic [9:0] distance_cm;
		logic       scanning;
		glyph_col_t led_column;
	} column_word_t;

	// Predicted state of the display.
	logic        was_active;
	logic [9:0]  held_cm;
	logic        sweeping;
	int unsigned column_at;
	int unsigned ticks_in_column;
	logic [15:0] column_ticks;

	column_word_t expected_words[$];

	function automatic logic [34:0] numeral_glyph(input int unsigned digit);
		case (digit)
			0: return {7'h7F, 7'h41, 7'h41, 7'h41, 7'h7F};
			1: return {7'h00, 7'h00, 7'h00, 7'h00, 7'h7F};
			2: return {7'h4F, 7'h49, 7'h49, 7'h49, 7'h79};
			3: return {7'h49, 7'h49, 7'h49, 7'h49, 7'h7F};
			4: return {7'h78, 7'h08, 7'h08, 7'h08, 7'h7F};
			5: return {7'h79, 7'h49, 7'h49, 7'h49, 7'h4F};
			6: return {7'h7F, 7'h49, 7'h49, 7'h49, 7'h4F};
			7: return {7'h40, 7'h40, 7'h40, 7'h40, 7'h7F};
			8: return {7'h7F, 7'h49, 7'h49, 7'h49, 7'h7F};
			default: return {7'h79, 7'h49, 7'h49, 7'h49, 7'h7F};
		endcase
	endfunction

	function automatic glyph_col_t glyph_slice(input logic [34:0] glyph, input int unsigned offset);
		return glyph[34 - 7 * offset -: 7];
	endfunction

	// LED rows for one column of the scan, given the held distance.
	function automatic glyph_col_t column_rows(input int unsigned col, input logic [9:0] cm);
		int unsigned hundreds, tens, units;
		hundreds = cm / 100;
		tens = (cm / 10) % 10;
		units = cm % 10;
		if (col >= FIRST_HUNDREDS && col < FIRST_HUNDREDS + GLYPH_COLUMNS)
			return glyph_slice(numeral_glyph(hundreds), col - FIRST_HUNDREDS);
		if (col >= FIRST_TENS && col < FIRST_TENS + GLYPH_COLUMNS)
			return glyph_slice(numeral_glyph(tens), col - FIRST_TENS);
		if (col >= FIRST_UNITS && col < FIRST_UNITS + GLYPH_COLUMNS)
			return glyph_slice(numeral_glyph(units), col - FIRST_UNITS);
		if (col >= FIRST_C && col < FIRST_C + GLYPH_COLUMNS)
			return glyph_slice(GLYPH_C, col - FIRST_C);
		if (col >= FIRST_M && col < FIRST_M + GLYPH_COLUMNS)
			return glyph_slice(GLYPH_M, col - FIRST_M);
		return '0;
	endfunction

	// Advances the display by one tick and returns the word it drives.
	function automatic column_word_t predict_word(input logic swing_level,
			input logic [31:0] echo_ticks);
		logic         active;
		logic [63:0]  cm_wide;
		column_word_t word;
		active = !swing_level;
		word = '0;
		// Sensor edges count only outside a scan.
		if (!sweeping) begin
			if (active != was_active) begin
				if (active) begin
					cm_wide = ({32'd0, echo_ticks} * 64'd67) / 64'd64000;
					held_cm = (cm_wide > {54'd0, CM_LIMIT}) ? CM_LIMIT : cm_wide[9:0];
					distances_latched++;
				end else begin
					sweeping = 1'b1;
					column_at = 0;
					ticks_in_column = 0;
					scans_started++;
				end
			end
			was_active = active;
		end
		// A column time of zero acts as one tick per column.
		if (sweeping) begin
			word.led_column = column_rows(column_at, held_cm);
			word.scanning = 1'b1;
			if (ticks_in_column + 1 >= column_ticks) begin
				ticks_in_column = 0;
				column_at++;
				if (column_at >= COLUMNS) begin
					sweeping = 1'b0;
					column_at = 0;
				end
			end else begin
				ticks_in_column++;
			end
		end
		word.distance_cm = held_cm;
		return word;
	endfunction

	// Watch the register port and both streams; compare each result word in order.
	always @(posedge clk or negedge arst_n) begin
		column_word_t got, want;
		if (!arst_n) begin
			was_active = 1'b0;
			held_cm = '0;
			sweeping = 1'b0;
			column_at = 0;
			ticks_in_column = 0;
			column_ticks = COLUMN_TICKS_RESET;
			expected_words.delete();
			fail_count = 0;
			pending = 0;
			checked_count = 0;
			scans_started = 0;
			distances_latched = 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr[2] == REG_COLUMN_TICKS)
				column_ticks = pwdata[15:0];
			if (s_tvalid && s_tready)
				expected_words.push_back(predict_word(s_tdata[0], s_tdata[32:1]));
			if (m_tvalid && m_tready) begin
				got = m_tdata[17:0];
				if (expected_words.size() == 0) begin
					$error("result word 0x%0h arrived with no word expected", m_tdata);
					fail_count++;
				end else begin
					want = expected_words.pop_front();
					if (got.led_column !== want.led_column) begin
						$error("led_column: expected 0x%0h, got 0x%0h",
							want.led_column, got.led_column);
						fail_count++;
					end
					if (got.scanning !== want.scanning) begin
						$error("scanning: expected %0b, got %0b", want.scanning, got.scanning);
						fail_count++;
					end
					if (got.distance_cm !== want.distance_cm) begin
						$error("distance_cm: expected %0d, got %0d",
							want.distance_cm, got.distance_cm);
						fail_count++;
					end
					checked_count++;
				end
			end
			pending = expected_words.size();
		end
	end

endmodule

>>> tb/tb_swing_display_distance_scanner_core.sv
module tb_swing_display_distance_scanner_core;
	timeunit 1ns;
	timeprecision 1ps;
	import sdds_pkg::*;

	localparam int unsigned COLUMNS = 80;
	localparam logic [2:0] COLUMN_TICKS_ADDR = {REG_COLUMN_TICKS, 2'b00};
	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned LONG_HOLD = 400;
	localparam int unsigned HOLD_AFTER_WORDS = 700;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;  // [0] swing_level, [32:1] echo_ticks, [39:33] zero
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;  // [6:0] led_column, [7] scanning, [17:8] distance_cm
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	int unsigned fail_count;
	int unsigned pending;
	int unsigned checked_count;
	int unsigned scans_started;
	int unsigned distances_latched;

	// Sender and phase bookkeeping.
	int unsigned words_sent = 0;
	int unsigned burst_left = 0;
	int unsigned phase_end = 0;
	int unsigned cur_ticks = COLUMN_TICKS_RESET;
	int unsigned cycle_count = 0;
	bit          gaps_on = 1'b1;

	swing_display_distance_scanner_core #(.COLUMNS(COLUMNS)) uut (.*);

	swing_display_scan_checker #(.COLUMNS(COLUMNS)) scan_checker (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Offers one word; a new burst may open with a short gap.
	task automatic send_tick(input logic level, input logic [31:0] echo);
		int unsigned gap;
		gap = 0;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			if (gaps_on)
				gap = $urandom_range(1, 6);
		end
		@(negedge clk);
		repeat (gap) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {7'd0, echo, level};
		do @(posedge clk); while (!s_tready);
		burst_left--;
		words_sent++;
	endtask

	// Waits until every result is back, then writes the column time.
	task automatic write_column_ticks(input logic [15:0] value);
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= COLUMN_TICKS_ADDR;
		pwdata <= {16'($urandom), value};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		cur_ticks = value;
	endtask

	// Smallest echo count that reads as the given distance.
	function automatic logic [31:0] echo_for_cm(input int unsigned cm);
		return (cm * 64000 + 66) / 67;
	endfunction

	function automatic logic [31:0] pick_echo();
		case ($urandom_range(9)) inside
			[0:3]: return echo_for_cm($urandom_range(999)) + $urandom_range(954);
			4: return echo_for_cm($urandom_range(1, 999)) - 1;
			5: return 32'd955204 + $urandom_range(40);
			[6:7]: return $urandom;
			8: return $urandom_range(2000);
			default: return $urandom >> $urandom_range(31);
		endcase
	endfunction

	// One swing: rest, turn active with an echo, turn inactive and ride out the scan.
	task automatic swing_cycle(input logic [31:0] echo);
		int unsigned idle_len, active_len, scan_len;
		bit          tidy;
		gaps_on = ($urandom_range(3) != 0);
		idle_len = $urandom_range(3);
		active_len = $urandom_range(1, 4);
		scan_len = COLUMNS * ((cur_ticks == 0) ? 1 : cur_ticks);
		tidy = ($urandom_range(5) != 0);
		for (int unsigned i = 0; i < idle_len && words_sent < phase_end; i++)
			send_tick(1'b1, $urandom);
		for (int unsigned i = 0; i < active_len && words_sent < phase_end; i++)
			send_tick(1'b0, (i == 0) ? echo : $urandom);
		if (words_sent < phase_end)
			send_tick(1'b1, $urandom);
		// Edges inside the scan are noise; a tidy swing ends it inactive.
		for (int unsigned i = 1; i < scan_len && words_sent < phase_end; i++)
			send_tick((tidy && i + 3 >= scan_len) ? 1'b1 : 1'($urandom), $urandom);
	endtask

	// Receiver: ready runs broken by short stalls, and one long hold-off.
	initial begin
		int unsigned run_len, stall_len;
		bit          held;
		held = 1'b0;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (!held && checked_count >= HOLD_AFTER_WORDS) begin
				held = 1'b1;
				repeat (LONG_HOLD) begin
					@(negedge clk);
					m_tready <= 1'b0;
				end
			end
			run_len = ($urandom_range(9) == 0) ? 150 : $urandom_range(1, 25);
			stall_len = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
			repeat (run_len) begin
				@(negedge clk);
				m_tready <= 1'b1;
			end
			repeat (stall_len) begin
				@(negedge clk);
				m_tready <= 1'b0;
			end
		end
	end

	// Watchdog.
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Run stopped after %0d cycles with %0d results outstanding.",
			cycle_count, pending);
		$display("simulation failed");
		$finish;
	end

	// Stimulus and verdict.
	initial begin
		logic [31:0] corner_echoes [6];
		int unsigned phase_ticks [6];
		int unsigned phase_words [6];
		corner_echoes = '{32'd0, 32'd954, 32'd956, 32'd955223, 32'd955224, 32'hFFFF_FFFF};
		phase_ticks = '{2, 0, 3, 65535, 1, 0};
		phase_words = '{250, 150, 200, 100, 300, 250};
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset column time: a saturated echo, then a scan cut short by the next write.
		phase_end = 32'hFFFF_FFFF;
		send_tick(1'b1, 32'hFFFF_FFFF);
		send_tick(1'b0, 32'hFFFF_FFFF);
		send_tick(1'b0, 32'd0);
		send_tick(1'b1, 32'd0);
		repeat (20) send_tick(1'($urandom), $urandom);

		// One tick per column: finish the scan, then the distance corners.
		write_column_ticks(16'd1);
		repeat (COLUMNS) send_tick(1'b1, $urandom);
		foreach (corner_echoes[i])
			swing_cycle(corner_echoes[i]);

		// Random swings under several column times, with some raw noise between them.
		foreach (phase_ticks[p]) begin
			write_column_ticks((p == 5) ? 16'($urandom_range(1, 4)) : 16'(phase_ticks[p]));
			phase_end = words_sent + phase_words[p];
			while (words_sent < phase_end) begin
				if ($urandom_range(7) == 0) begin
					gaps_on = 1'b1;
					repeat ($urandom_range(1, 10)) send_tick(1'($urandom), $urandom);
				end else begin
					swing_cycle(pick_echo());
				end
			end
		end

		// Drain and let the output register settle.
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);

		$display("Drove %0d input words under column times 1191, 1, 2, 0, 3, 65535 and %s",
			words_sent, "a random small one;");
		$display("checked %0d result words over %0d scans and %0d latched distances.",
			checked_count, scans_started, distances_latched);
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

>>> sim.f
design/sdds_pkg.sv
design/swing_display_distance_scanner_core.sv
tb/swing_display_scan_checker.sv
tb/tb_swing_display_distance_scanner_core.sv
